[design/line_pixel_rasterizer_assert.svh]
// assertion macros used by the checker file of the line pixel rasterizer
// depends on nothing; included by bare file name
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// next-cycle implication, disabled while reset is low
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

[design/lpr_pkg.sv]
// shared types and constants of the line pixel rasterizer
// depends on nothing
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int COLOR_BITS = 24;

    // item kind carried on s_tuser
    localparam logic OP_LINE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_line;
        logic step;
    } lpr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } lpr_status_t;

endpackage

[design/line_pixel_rasterizer.sv]
// a tick item accepted while a line is being drawn shows its pixel on m_tdata in the next cycle
// throughput: one item per cycle unless a pixel stalls on m_tready; the output register frees in the cycle it is taken
// a line item only sets up the line state and gives no result
// each pixel comes from an incremental quotient and remainder, no divider in the path
// reset: aresetn low synchronously clears the controller state and the output valid; datapath registers are not reset
`timescale 1ns / 1ps

// top level of the line pixel rasterizer
// depends on lpr_pkg, lpr_ctrl, lpr_datapath
module line_pixel_rasterizer #(
    parameter int COORD_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input item channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_x, first_y, second_x, second_y, line_color, zero pad
    input  logic [((4 * COORD_BITS + lpr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // op: 0 starts a line, 1 ticks the next pixel
    input  logic                  s_tuser,
    // pixel channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pix_x, pix_y, pix_color, zero pad
    output logic [((2 * COORD_BITS + lpr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // last pixel of the line
    output logic                  m_tlast
);

    // packed widths, rounded up to whole bytes
    localparam int CB       = COORD_BITS;
    localparam int CLR      = lpr_pkg::COLOR_BITS;
    localparam int M_FIELDS = 2 * CB + CLR;
    localparam int M_DATA_W = ((M_FIELDS + 7) / 8) * 8;

    lpr_pkg::lpr_cmd_t    cmd;
    lpr_pkg::lpr_status_t status;

    logic [CB-1:0]  pix_x, pix_y;
    logic [CLR-1:0] pix_color;
    logic           pix_last;

    // handshake and line state
    lpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // setup and per-pixel stepping
    lpr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .status     (status),
        .first_x    (s_tdata[CB-1:0]),
        .first_y    (s_tdata[2*CB-1:CB]),
        .second_x   (s_tdata[3*CB-1:2*CB]),
        .second_y   (s_tdata[4*CB-1:3*CB]),
        .line_color (s_tdata[4*CB+CLR-1:4*CB]),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .pix_color  (pix_color),
        .pix_last   (pix_last)
    );

    // pack the pixel, pad bits stay zero
    always_comb begin
        m_tdata                = '0;
        m_tdata[M_FIELDS-1:0]  = {pix_color, pix_y, pix_x};
    end

    assign m_tlast = pix_last;

endmodule

[design/lpr_ctrl.sv]
// controller of the line pixel rasterizer: line state and output handshake
// depends on lpr_pkg
`timescale 1ns / 1ps

module lpr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_op,
    output logic                m_tvalid,
    input  logic                m_tready,
    output lpr_pkg::lpr_cmd_t   cmd,
    input  lpr_pkg::lpr_status_t status
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd.load_line = accept && (s_op == lpr_pkg::OP_LINE);
        cmd.step      = accept && (s_op == lpr_pkg::OP_TICK) && (state_reg == ST_DRAW);
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.step) begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load_line) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                // a new line drops the current one
                if (cmd.load_line) begin
                    state_next = ST_DRAW;
                end else if (cmd.step && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/lpr_datapath.sv]
// datapath of the line pixel rasterizer: line setup, incremental minor step, pixel register
// depends on lpr_pkg
`timescale 1ns / 1ps

module lpr_datapath #(
    parameter int COORD_BITS = 8
) (
    input  logic                              aclk,
    input  lpr_pkg::lpr_cmd_t                 cmd,
    output lpr_pkg::lpr_status_t              status,
    input  logic [COORD_BITS-1:0]             first_x,
    input  logic [COORD_BITS-1:0]             first_y,
    input  logic [COORD_BITS-1:0]             second_x,
    input  logic [COORD_BITS-1:0]             second_y,
    input  logic [lpr_pkg::COLOR_BITS-1:0]    line_color,
    output logic [COORD_BITS-1:0]             pix_x,
    output logic [COORD_BITS-1:0]             pix_y,
    output logic [lpr_pkg::COLOR_BITS-1:0]    pix_color,
    output logic                              pix_last
);

    localparam int CB = COORD_BITS;

    // line state
    logic                           major_is_y_reg, major_is_y_next;
    logic [CB-1:0]                  cur_major_reg, cur_major_next;
    logic [CB-1:0]                  cur_minor_reg, cur_minor_next;
    logic                           minor_neg_reg, minor_neg_next;
    logic [CB-1:0]                  minor_mag_reg, minor_mag_next;
    logic [CB-1:0]                  major_len_reg, major_len_next;
    logic [CB-1:0]                  step_reg, step_next;
    logic [CB:0]                    rem_reg, rem_next;
    logic [lpr_pkg::COLOR_BITS-1:0] color_reg, color_next;

    // pixel output
    logic [CB-1:0]                  pix_x_reg, pix_y_reg;
    logic [lpr_pkg::COLOR_BITS-1:0] pix_color_reg;
    logic                           pix_last_reg;

    // setup terms
    logic [CB-1:0] dx, dy;
    logic          y_major;
    logic [CB-1:0] sa, sb, ea, eb;

    // step terms
    logic [CB:0]   rem_sum;
    logic          carry;

    assign status.last = (step_reg == major_len_reg);

    always_comb begin
        dx      = (first_x > second_x) ? first_x - second_x : second_x - first_x;
        dy      = (first_y > second_y) ? first_y - second_y : second_y - first_y;
        y_major = dy > dx;
        if (y_major) begin
            if (second_y > first_y) begin
                sa = first_y;  sb = first_x;  ea = second_y; eb = second_x;
            end else begin
                sa = second_y; sb = second_x; ea = first_y;  eb = first_x;
            end
        end else begin
            if (second_x > first_x) begin
                sa = first_x;  sb = first_y;  ea = second_x; eb = second_y;
            end else begin
                sa = second_x; sb = second_y; ea = first_x;  eb = first_y;
            end
        end
    end

    // minor moves at most one per major step since |dminor| <= dmajor
    assign rem_sum = rem_reg + {1'b0, minor_mag_reg};
    assign carry   = (major_len_reg != '0) && (rem_sum >= {1'b0, major_len_reg});

    always_comb begin
        major_is_y_next = major_is_y_reg;
        cur_major_next  = cur_major_reg;
        cur_minor_next  = cur_minor_reg;
        minor_neg_next  = minor_neg_reg;
        minor_mag_next  = minor_mag_reg;
        major_len_next  = major_len_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        color_next      = color_reg;
        priority if (cmd.load_line) begin
            major_is_y_next = y_major;
            cur_major_next  = sa;
            cur_minor_next  = sb;
            minor_neg_next  = eb < sb;
            minor_mag_next  = (eb < sb) ? sb - eb : eb - sb;
            major_len_next  = ea - sa;
            step_next       = '0;
            rem_next        = '0;
            color_next      = line_color;
        end else if (cmd.step) begin
            cur_major_next = cur_major_reg + 1'b1;
            step_next      = step_reg + 1'b1;
            rem_next       = carry ? rem_sum - {1'b0, major_len_reg} : rem_sum;
            if (carry) begin
                cur_minor_next = minor_neg_reg ? cur_minor_reg - 1'b1 : cur_minor_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        major_is_y_reg <= major_is_y_next;
        cur_major_reg  <= cur_major_next;
        cur_minor_reg  <= cur_minor_next;
        minor_neg_reg  <= minor_neg_next;
        minor_mag_reg  <= minor_mag_next;
        major_len_reg  <= major_len_next;
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        color_reg      <= color_next;
        if (cmd.step) begin
            pix_x_reg     <= major_is_y_reg ? cur_minor_reg : cur_major_reg;
            pix_y_reg     <= major_is_y_reg ? cur_major_reg : cur_minor_reg;
            pix_color_reg <= color_reg;
            pix_last_reg  <= status.last;
        end
    end

    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign pix_color = pix_color_reg;
    assign pix_last  = pix_last_reg;

endmodule

[design/lpr_checker.sv]
// port-level checks of the line pixel rasterizer, bound to the top level
// depends on line_pixel_rasterizer_assert.svh and line_pixel_rasterizer
`timescale 1ns / 1ps
`include "line_pixel_rasterizer_assert.svh"

module lpr_checker #(
    parameter int M_DATA_W = 40
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    // a stalled pixel stays offered and unchanged
    `LPR_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `LPR_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready,
                     $stable(m_tdata) && $stable(m_tlast))
    // a new pixel only follows an accepted tick
    `LPR_ASSERT_NOW(a_pixel_from_tick, aclk, aresetn, $rose(m_tvalid),
                    $past(s_tvalid && s_tready && s_tuser))
    // a line item never yields a pixel
    `LPR_ASSERT_NEXT(a_line_silent, aclk, aresetn,
                     s_tvalid && s_tready && !s_tuser && (!m_tvalid || m_tready), !m_tvalid)

endmodule

bind line_pixel_rasterizer lpr_checker #(
    .M_DATA_W (M_DATA_W)
) u_lpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
